### rtl/bat_pkg.sv
// ----------------------------------------------------------------------------
// bat_pkg
// Shared types, sizes and codes for the breakpoint address table.
// ----------------------------------------------------------------------------
package bat_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int ADDR_W      = 16;
  localparam int OP_W        = 2;
  localparam int COUNT_OUT_W = 5;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [OP_W-1:0] {
    OP_SET   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EXEC,
    ST_MOVE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [ADDR_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } ram_req_t;

  typedef struct packed {
    logic                   found;
    logic [COUNT_OUT_W-1:0] entry_count;
    logic                   full_reject;
  } res_t;

  function automatic logic [COUNT_OUT_W-1:0] count_out(input logic [CNT_W-1:0] c);
    logic [CNT_W+COUNT_OUT_W-1:0] w;
    w = (CNT_W + COUNT_OUT_W)'(c);
    return w[COUNT_OUT_W-1:0];
  endfunction

endpackage

### rtl/bat_if.sv
// ----------------------------------------------------------------------------
// bat_if
// Valid/ready channels for request and response beats.
// ----------------------------------------------------------------------------
interface bat_in_if;
  import bat_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output opcode, output address, input ready);
  modport sink   (input valid, input opcode, input address, output ready);
endinterface

interface bat_out_if;
  import bat_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   found;
  logic [COUNT_OUT_W-1:0] entry_count;
  logic                   full_reject;

  modport source (output valid, output found, output entry_count, output full_reject,
                  input ready);
  modport sink   (input valid, input found, input entry_count, input full_reject,
                  output ready);
endinterface

### rtl/bat_ram.sv
// ----------------------------------------------------------------------------
// bat_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bat_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/bat_seq.sv
// ----------------------------------------------------------------------------
// bat_seq
// Sequencer: scans the valid entries through one shared comparator, then
// appends, moves the last entry down, or leaves the table as it is.
// ----------------------------------------------------------------------------
module bat_seq (
  input  logic                      clk,
  input  logic                      rst,
  bat_in_if.sink                    req,
  output bat_pkg::ram_req_t         ram,
  input  logic [bat_pkg::ADDR_W-1:0] rd_data,
  output bat_pkg::res_t             res,
  output logic                      res_valid,
  input  logic                      res_take
);
  import bat_pkg::*;

  state_t            state, state_next;
  op_t               op;
  logic [ADDR_W-1:0] addr;
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  cmp_idx;
  logic              cmp_vld;
  logic              hit;
  logic [IDX_W-1:0]  slot;
  logic              reject;
  logic [IDX_W-1:0]  last_idx;
  logic              match;
  logic              accept;

  assign last_idx = IDX_W'(count - CNT_W'(1));
  assign match    = cmp_vld && (rd_data == addr);
  assign accept   = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    res_valid  = 1'b0;
    ram        = '0;
    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = (count == '0) ? ST_EXEC : ST_SCAN;
        end
      end
      ST_SCAN: begin
        ram.raddr = idx;
        if (idx == last_idx) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_DONE;
        case (op)
          OP_SET: begin
            if (!hit && count < CNT_W'(MAX_ENTRIES)) begin
              ram.we    = 1'b1;
              ram.waddr = IDX_W'(count);
              ram.wdata = addr;
            end
          end
          OP_CLEAR: begin
            if (hit) begin
              ram.raddr  = last_idx;
              state_next = ST_MOVE;
            end
          end
          default: ;
        endcase
      end
      ST_MOVE: begin
        ram.we     = 1'b1;
        ram.waddr  = slot;
        ram.wdata  = rd_data;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      cmp_vld <= 1'b0;
    end else begin
      cmp_vld <= (state == ST_SCAN);
      if (state == ST_EXEC && op == OP_SET && !hit && count < CNT_W'(MAX_ENTRIES)) begin
        count <= count + CNT_W'(1);
      end
      if (state == ST_MOVE) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= idx;
    if (accept) begin
      op     <= op_t'(req.opcode);
      addr   <= req.address;
      idx    <= '0;
      hit    <= 1'b0;
      reject <= 1'b0;
    end else begin
      if (state == ST_SCAN && idx != last_idx) begin
        idx <= idx + IDX_W'(1);
      end
      if (match && !hit) begin
        hit  <= 1'b1;
        slot <= cmp_idx;
      end
      if (state == ST_EXEC && op == OP_SET && !hit && count == CNT_W'(MAX_ENTRIES)) begin
        reject <= 1'b1;
      end
    end
  end

  assign res.found       = hit;
  assign res.entry_count = count_out(count);
  assign res.full_reject = reject;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ENTRIES))
    else $error("entry count above capacity");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> CNT_W'(idx) < count)
    else $error("scan index beyond valid entries");

  a_reject_miss: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.full_reject |-> !res.found && count == CNT_W'(MAX_ENTRIES))
    else $error("reject on hit or non-full table");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE)
    else $error("sequencer idle right after accepting a beat");

  a_move_on_hit: assert property (@(posedge clk) disable iff (rst)
    state == ST_MOVE |-> hit && op == OP_CLEAR && count != '0)
    else $error("entry move without a matching clear");

endmodule

### rtl/breakpoint_address_table.sv
// ----------------------------------------------------------------------------
// breakpoint_address_table
// Set, clear and query of breakpoint addresses in a compact table.
// ----------------------------------------------------------------------------
// Each request beat scans the valid entries of the table (at most 16): the
// entries are read one a cycle from the table RAM and compared against the
// address by one comparator, then a set of a new address writes one slot if
// the table has room, or a clear that hits reads the last entry and writes
// it into the freed slot. One response beat per request; a finished response
// sits in an output register so the next request can be taken while it
// waits. No configuration, no clearing pass after reset.
module breakpoint_address_table (
  input  logic    clk,
  input  logic    rst,
  bat_in_if.sink  req,
  bat_out_if.source rsp
);
  import bat_pkg::*;

  ram_req_t          ram;
  logic [ADDR_W-1:0] rd_data;
  res_t              res;
  logic              res_valid;
  logic              res_take;
  res_t              out_q;
  logic              out_valid;

  bat_ram #(
    .WIDTH (ADDR_W),
    .DEPTH (MAX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram.we),
    .waddr (ram.waddr),
    .wdata (ram.wdata),
    .raddr (ram.raddr),
    .rdata (rd_data)
  );

  bat_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .ram       (ram),
    .rd_data   (rd_data),
    .res       (res),
    .res_valid (res_valid),
    .res_take  (res_take)
  );

  assign res_take = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_q <= res;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.found       = out_q.found;
  assign rsp.entry_count = out_q.entry_count;
  assign rsp.full_reject = out_q.full_reject;

endmodule
